@@ sv/kbt_pkg.sv @@
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types and constants of the keypad bus transceiver.
// ----------------------------------------------------------------------------
package kbt_pkg;

    localparam int STATUS_BITS   = 32;
    localparam int PATTERN_W     = 32;
    localparam int PAT_IDX_W     = $clog2(PATTERN_W);
    localparam int CNT_W         = $clog2(STATUS_BITS + 2);
    localparam int LOW_W         = 12;
    localparam int PPK_W         = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [LOW_W-1:0]       LOW_MAX       = {LOW_W{1'b1}};
    localparam logic [LOW_W-1:0]       GAP_RESET     = LOW_W'(400);
    localparam logic [PPK_W-1:0]       PPK_RESET     = PPK_W'(2);
    localparam logic [CNT_W-1:0]       RX_LAST_PULSE = CNT_W'(STATUS_BITS + 1);
    localparam logic [CNT_W-1:0]       TX_LAST_PULSE = CNT_W'(STATUS_BITS);

    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TICKS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_PPK       = CFG_INDEX_W'(1);

    typedef struct packed {
        logic                 clock_sense;
        logic                 data_sense;
        logic                 send_request;
        logic [PATTERN_W-1:0] key_pattern;
    } sample_t;

    typedef struct packed {
        logic                   shunt_drive;
        logic                   status_valid;
        logic [STATUS_BITS-1:0] status_word;
        logic                   sending;
    } result_t;

    typedef struct packed {
        logic gap;
        logic high_edge;
        logic low_edge;
    } line_t;

    typedef enum logic [2:0] {
        TX_IDLE = 3'b001,
        TX_WAIT = 3'b010,
        TX_SEND = 3'b100
    } tx_phase_t;

endpackage

@@ sv/kbt_line.sv @@
// ----------------------------------------------------------------------------
// kbt_line
// Clock line tracking: low-time counter, frame gap and pulse edge detect.
// ----------------------------------------------------------------------------
module kbt_line
    import kbt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             clock_sense,
    input  logic [LOW_W-1:0] gap_ticks,
    output line_t            line
);

    logic [LOW_W-1:0] low_time_reg;
    logic [LOW_W-1:0] low_time_next;
    logic [LOW_W-1:0] low_inc;
    logic             prev_clock_reg;

    always_comb
    begin
        low_inc        = (low_time_reg < LOW_MAX) ? low_time_reg + LOW_W'(1) : low_time_reg;
        low_time_next  = clock_sense ? low_inc : '0;
        line.gap       = clock_sense && (low_inc > gap_ticks);
        line.high_edge = prev_clock_reg && !clock_sense;
        line.low_edge  = !prev_clock_reg && clock_sense;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_time_reg   <= '0;
            prev_clock_reg <= 1'b1;
        end
        else if (advance)
        begin
            low_time_reg   <= low_time_next;
            prev_clock_reg <= clock_sense;
        end
    end

endmodule

@@ sv/kbt_rx.sv @@
// ----------------------------------------------------------------------------
// kbt_rx
// Status frame receiver: shifts in one bit per clock pulse after a gap.
// ----------------------------------------------------------------------------
module kbt_rx
    import kbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  line_t                  line,
    input  logic                   data_sense,
    output logic                   status_valid,
    output logic [STATUS_BITS-1:0] status_next
);

    logic                   armed_reg;
    logic                   armed_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [STATUS_BITS-1:0] shift_reg;
    logic [STATUS_BITS-1:0] shift_next;
    logic [STATUS_BITS-1:0] status_reg;

    always_comb
    begin
        armed_next   = armed_reg;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        status_next  = status_reg;
        status_valid = 1'b0;
        if (line.gap)
        begin
            armed_next = 1'b1;
            cnt_next   = '0;
            shift_next = '0;
        end
        else if (line.high_edge && armed_reg)
        begin
            shift_next = {~data_sense, shift_reg[STATUS_BITS-1:1]};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_next >= RX_LAST_PULSE)
            begin
                status_next  = shift_next;
                status_valid = 1'b1;
                armed_next   = 1'b0;
                cnt_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            cnt_reg    <= '0;
            shift_reg  <= '0;
            status_reg <= '0;
        end
        else if (advance)
        begin
            armed_reg  <= armed_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            status_reg <= status_next;
        end
    end

    a_rx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < RX_LAST_PULSE)
        else $error("rx pulse count past frame length");

    a_rx_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> cnt_reg == '0)
        else $error("rx counting while not armed");

endmodule

@@ sv/kbt_tx.sv @@
// ----------------------------------------------------------------------------
// kbt_tx
// Key sender: waits for a gap, then shunts data after pulses with 0 bits.
// ----------------------------------------------------------------------------
module kbt_tx
    import kbt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  line_t                line,
    input  logic                 send_request,
    input  logic [PATTERN_W-1:0] key_pattern,
    input  logic [PPK_W-1:0]     packets_per_key,
    output logic                 shunt_next,
    output logic                 sending_next
);

    tx_phase_t            phase_reg;
    tx_phase_t            phase_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]     bit_idx;
    logic [PPK_W-1:0]     frames_reg;
    logic [PPK_W-1:0]     frames_next;
    logic [PPK_W-1:0]     frames_dec;
    logic [PATTERN_W-1:0] pattern_reg;
    logic [PATTERN_W-1:0] pattern_next;
    logic                 shunt_reg;
    logic                 pat_bit;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        frames_next  = frames_reg;
        pattern_next = pattern_reg;
        shunt_next   = shunt_reg;
        bit_idx      = cnt_reg - CNT_W'(1);
        pat_bit      = (bit_idx >= CNT_W'(PATTERN_W)) ? 1'b1
                                                      : pattern_reg[bit_idx[PAT_IDX_W-1:0]];
        frames_dec   = (frames_reg != '0) ? frames_reg - PPK_W'(1) : frames_reg;

        if (line.gap && phase_reg != TX_IDLE)
        begin
            phase_next = TX_SEND;
            cnt_next   = '0;
            shunt_next = 1'b0;
        end
        else if (phase_reg == TX_SEND)
        begin
            if (line.high_edge)
            begin
                shunt_next = 1'b0;
                if (cnt_reg >= TX_LAST_PULSE)
                begin
                    cnt_next    = '0;
                    frames_next = frames_dec;
                    phase_next  = (frames_dec == '0) ? TX_IDLE : TX_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            else if (line.low_edge && cnt_reg != '0 && !pat_bit)
            begin
                shunt_next = 1'b1;
            end
        end

        if (send_request && phase_next == TX_IDLE)
        begin
            pattern_next = key_pattern;
            frames_next  = (packets_per_key != '0) ? packets_per_key : PPK_W'(1);
            cnt_next     = '0;
            shunt_next   = 1'b0;
            phase_next   = TX_WAIT;
        end

        sending_next = (phase_next != TX_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= TX_IDLE;
            cnt_reg     <= '0;
            frames_reg  <= '0;
            pattern_reg <= '0;
            shunt_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            frames_reg  <= frames_next;
            pattern_reg <= pattern_next;
            shunt_reg   <= shunt_next;
        end
    end

    a_tx_shunt_send: assert property (@(posedge clk) disable iff (!rst_n)
        shunt_reg |-> phase_reg == TX_SEND)
        else $error("shunt driven outside send phase");

    a_tx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= TX_LAST_PULSE)
        else $error("tx pulse count past frame length");

endmodule

@@ sv/kbt_skid.sv @@
// ----------------------------------------------------------------------------
// kbt_skid
// Two-entry result buffer; input stall comes from a register only.
// ----------------------------------------------------------------------------
module kbt_skid
    import kbt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !result_stall)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !result_stall)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output slot");

endmodule

@@ sv/keypad_bus_transceiver_core.sv @@
// ----------------------------------------------------------------------------
// keypad_bus_transceiver_core
// Alarm keypad bus transceiver: status frame receiver and key sender.
// ----------------------------------------------------------------------------
// Each sample beat carries one tick of the sensed bus clock and data lines
// plus a send request with its key pattern. Every sample beat yields one
// result beat: shunt drive, a frame-complete flag, the last status word and
// the sending flag, all reflecting the state after that tick.
// Each result beat is registered in the result buffer, and a sample can be
// accepted every cycle while sample_stall is low. The result side has a
// two-entry buffer, so sample_stall only rises once both entries hold
// results not yet taken; it is driven from a register. Configuration
// (gap_ticks index 0, packets_per_key index 1) is written via
// cfg_wr_en/cfg_index/cfg_data; the user must do so only while no beats
// are in flight, as the block itself does not enforce this. Reset clears
// all state: gap_ticks 400, packets_per_key 2, transmitter idle, receiver
// waiting for a gap, status word zero, shunt released.
// ----------------------------------------------------------------------------
module keypad_bus_transceiver_core
    import kbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [LOW_W-1:0]       gap_ticks_reg;
    logic [PPK_W-1:0]       ppk_reg;
    logic                   advance;
    line_t                  line;
    logic                   status_valid;
    logic [STATUS_BITS-1:0] status_next;
    logic                   shunt_next;
    logic                   sending_next;
    logic                   buf_full;
    result_t                push_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ticks_reg <= GAP_RESET;
            ppk_reg       <= PPK_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_GAP_TICKS: gap_ticks_reg <= cfg_data[LOW_W-1:0];
                CFG_PPK:       ppk_reg       <= cfg_data[PPK_W-1:0];
                default:       ;
            endcase
        end
    end

    assign sample_stall = buf_full;
    assign advance      = sample_valid && !buf_full;

    kbt_line u_line (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .clock_sense (sample.clock_sense),
        .gap_ticks   (gap_ticks_reg),
        .line        (line)
    );

    kbt_rx u_rx (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .line         (line),
        .data_sense   (sample.data_sense),
        .status_valid (status_valid),
        .status_next  (status_next)
    );

    kbt_tx u_tx (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .line            (line),
        .send_request    (sample.send_request),
        .key_pattern     (sample.key_pattern),
        .packets_per_key (ppk_reg),
        .shunt_next      (shunt_next),
        .sending_next    (sending_next)
    );

    always_comb
    begin
        push_data.shunt_drive  = shunt_next;
        push_data.status_valid = status_valid;
        push_data.status_word  = status_next;
        push_data.sending      = sending_next;
    end

    kbt_skid u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (advance),
        .push_data    (push_data),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ tb/kbt_tick_checker.sv @@
// ----------------------------------------------------------------------------
// kbt_tick_checker
// Tick-level predictor and result checker for keypad_bus_transceiver_core.
// ----------------------------------------------------------------------------
// Watches the sample, result and configuration ports. It runs each accepted
// sample beat through a cycle-exact copy of the receiver and key sender and
// queues the predicted result beat. Each accepted result beat is then checked,
// field by field, against the oldest queued prediction. It reports the failure
// count and the number of predictions still waiting.
// ----------------------------------------------------------------------------
module kbt_tick_checker
    import kbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    input  logic                   sample_stall,
    input  sample_t                sample,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  result_t                result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    logic [LOW_W-1:0]       gap_ticks_q;
    logic [PPK_W-1:0]       ppk_q;

    logic [LOW_W-1:0]       low_time;
    logic                   prev_clock;
    logic                   rx_armed;
    logic [CNT_W-1:0]       rx_pulses;
    logic [STATUS_BITS-1:0] rx_shift;
    logic [STATUS_BITS-1:0] last_status;
    logic [PATTERN_W-1:0]   tx_pattern;
    tx_phase_t              tx_phase;
    logic [CNT_W-1:0]       tx_pulses;
    logic [PPK_W-1:0]       frames_left;
    logic                   shunt;

    result_t                tick_results_q[$];

    function automatic result_t step_bus(input sample_t s);
        result_t r;
        logic    gap;
        logic    high_edge;
        logic    low_edge;
        gap       = 1'b0;
        high_edge = prev_clock && !s.clock_sense;
        low_edge  = !prev_clock && s.clock_sense;
        r.status_valid = 1'b0;

        if (s.clock_sense)
        begin
            if (low_time != LOW_MAX)
                low_time = low_time + 1'b1;
            gap = low_time > gap_ticks_q;
        end
        else
        begin
            low_time = '0;
        end

        if (gap)
        begin
            rx_armed  = 1'b1;
            rx_pulses = '0;
            rx_shift  = '0;
        end
        else if (high_edge && rx_armed)
        begin
            rx_shift  = {~s.data_sense, rx_shift[STATUS_BITS-1:1]};
            rx_pulses = rx_pulses + 1'b1;
            if (rx_pulses >= RX_LAST_PULSE)
            begin
                last_status    = rx_shift;
                r.status_valid = 1'b1;
                rx_armed       = 1'b0;
                rx_pulses      = '0;
            end
        end

        if (gap && tx_phase != TX_IDLE)
        begin
            tx_phase  = TX_SEND;
            tx_pulses = '0;
            shunt     = 1'b0;
        end
        else if (tx_phase == TX_SEND)
        begin
            if (high_edge)
            begin
                shunt = 1'b0;
                if (tx_pulses >= TX_LAST_PULSE)
                begin
                    tx_pulses = '0;
                    if (frames_left != 0)
                        frames_left = frames_left - 1'b1;
                    tx_phase = (frames_left == 0) ? TX_IDLE : TX_WAIT;
                end
                else
                begin
                    tx_pulses = tx_pulses + 1'b1;
                end
            end
            else if (low_edge && tx_pulses != 0)
            begin
                if (!tx_pattern[PAT_IDX_W'(tx_pulses - 1'b1)])
                    shunt = 1'b1;
            end
        end

        if (s.send_request && tx_phase == TX_IDLE)
        begin
            tx_pattern  = s.key_pattern;
            frames_left = (ppk_q == 0) ? PPK_W'(1) : ppk_q;
            tx_pulses   = '0;
            shunt       = 1'b0;
            tx_phase    = TX_WAIT;
        end

        prev_clock    = s.clock_sense;
        r.shunt_drive = shunt;
        r.status_word = last_status;
        r.sending     = (tx_phase != TX_IDLE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : check_beat
        result_t want;
        int      errs;
        if (!rst_n)
        begin
            gap_ticks_q = GAP_RESET;
            ppk_q       = PPK_RESET;
            low_time    = '0;
            prev_clock  = 1'b1;
            rx_armed    = 1'b0;
            rx_pulses   = '0;
            rx_shift    = '0;
            last_status = '0;
            tx_pattern  = '0;
            tx_phase    = TX_IDLE;
            tx_pulses   = '0;
            frames_left = '0;
            shunt       = 1'b0;
            tick_results_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_GAP_TICKS)
                    gap_ticks_q = cfg_data[LOW_W-1:0];
                else if (cfg_index == CFG_PPK)
                    ppk_q = cfg_data[PPK_W-1:0];
            end

            if (result_valid && !result_stall)
            begin
                if (tick_results_q.size() == 0)
                begin
                    $error("result beat with no sample beat outstanding");
                    errs++;
                end
                else
                begin
                    want = tick_results_q.pop_front();
                    if (result.shunt_drive !== want.shunt_drive)
                    begin
                        $error("shunt_drive: expected %0h, got %0h",
                               want.shunt_drive, result.shunt_drive);
                        errs++;
                    end
                    if (result.status_valid !== want.status_valid)
                    begin
                        $error("status_valid: expected %0h, got %0h",
                               want.status_valid, result.status_valid);
                        errs++;
                    end
                    if (result.status_word !== want.status_word)
                    begin
                        $error("status_word: expected %08h, got %08h",
                               want.status_word, result.status_word);
                        errs++;
                    end
                    if (result.sending !== want.sending)
                    begin
                        $error("sending: expected %0h, got %0h",
                               want.sending, result.sending);
                        errs++;
                    end
                end
            end

            if (sample_valid && !sample_stall)
                tick_results_q.push_back(step_bus(sample));

            pending    <= tick_results_q.size();
            fail_count <= fail_count + errs;
        end
    end

endmodule

@@ tb/tb_keypad_bus_transceiver_core.sv @@
// ----------------------------------------------------------------------------
// tb_keypad_bus_transceiver_core
// Bus-level stimulus and verdict for the keypad bus transceiver.
// ----------------------------------------------------------------------------
// Plays sampled keypad bus traffic into the block: frame gaps, 33-pulse
// status frames with random data, truncated and overlong frames, and gaps
// that fall in the middle of a frame. Random key requests are mixed in.
// The gap length and frames per key are changed between phases, with the
// extreme settings among them. Both sides of the block idle in random
// bursts, and at one point the receiver holds off long enough to back the
// block up. The checker beside the block predicts and compares each beat.
// ----------------------------------------------------------------------------
module tb_keypad_bus_transceiver_core;
    import kbt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;
    localparam int PHASE_ITEMS = 200;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    sample_t                sample       = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = CFG_GAP_TICKS;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int items_sent   = 0;
    int gap_setting  = int'(GAP_RESET);
    bit hold_go      = 1'b0;
    bit hold_done    = 1'b0;
    bit calm         = 1'b0;
    bit sender_idles = 1'b0;

    keypad_bus_transceiver_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    kbt_tick_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL keypad_bus_transceiver_core");
            $finish;
        end
    end

    // result side: short random stalls, one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic put_sample(input sample_t s);
        if (sender_idles && !calm && $urandom_range(0, 7) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do @(posedge clk); while (sample_stall);
        items_sent++;
    endtask

    task automatic put_tick(input logic clock_level);
        sample_t s;
        s.clock_sense  = clock_level;
        s.data_sense   = 1'($urandom);
        s.send_request = ($urandom_range(0, 23) == 0);
        s.key_pattern  = $urandom;
        put_sample(s);
    endtask

    // low_len ticks of clock low, then pulses clock-high/clock-low pairs
    task automatic bus_frame(input int low_len, input int pulses);
        repeat (low_len) put_tick(1'b1);
        repeat (pulses)
        begin
            repeat ($urandom_range(1, 3)) put_tick(1'b0);
            if (gap_setting < 64 && $urandom_range(0, 39) == 0)
                repeat (gap_setting + 1) put_tick(1'b1);
            else
                repeat ($urandom_range(1, gap_setting < 3 ? gap_setting : 3)) put_tick(1'b1);
        end
    endtask

    task automatic random_frames(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            sender_idles = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0)
                bus_frame($urandom_range(1, gap_setting), $urandom_range(0, 40));
            else
                bus_frame(gap_setting + $urandom_range(1, 4),
                          33 + int'($urandom_range(0, 5) == 0));
        end
    endtask

    task automatic drain;
        sample_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] gap_val,
                               input logic [CFG_DATA_W-1:0] ppk_val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_GAP_TICKS;
        cfg_data  <= gap_val;
        @(posedge clk);
        cfg_index <= CFG_PPK;
        cfg_data  <= ppk_val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        gap_setting = int'(gap_val);
    endtask

    initial
    begin
        sample_t s;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // request with an all-zero pattern, then a request while busy
        s = '0;
        s.send_request = 1'b1;
        put_sample(s);
        s.data_sense  = 1'b1;
        s.key_pattern = '1;
        put_sample(s);
        s.clock_sense  = 1'b1;
        s.send_request = 1'b0;
        put_sample(s);
        s.data_sense = 1'b0;
        put_sample(s);

        // reset settings: gap 400, two frames per key
        sender_idles = 1'b1;
        bus_frame(int'(GAP_RESET) + 2, 33);

        reconfigure(CFG_DATA_W'(1), CFG_DATA_W'(1));
        hold_go <= 1'b1;
        random_frames(PHASE_ITEMS);

        // largest gap setting: no gap is seen
        reconfigure(CFG_DATA_W'(LOW_MAX), CFG_DATA_W'(3));
        bus_frame(32, 33);

        reconfigure(CFG_DATA_W'(7), CFG_DATA_W'(0));
        random_frames(PHASE_ITEMS);

        reconfigure(CFG_DATA_W'(3), CFG_DATA_W'(3));
        random_frames(PHASE_ITEMS);

        reconfigure(CFG_DATA_W'(12), CFG_DATA_W'(2));
        random_frames(PHASE_ITEMS);
        calm <= 1'b1;
        random_frames(PHASE_ITEMS / 2);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS keypad_bus_transceiver_core");
        else
            $display("FAIL keypad_bus_transceiver_core");
        $finish;
    end

endmodule
